// ===== hdl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and codes for the message stream deframer: byte classes,
// the request passed from front to back, the result record and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

  // Type bytes
  localparam logic [7:0] TYPE_INIT  = 8'h69;  // 'i'
  localparam logic [7:0] TYPE_GATH  = 8'h67;  // 'g'
  localparam logic [7:0] TYPE_BCAST = 8'h62;  // 'b'
  localparam logic [7:0] TYPE_KEEP  = 8'h6b;  // 'k'

  // Event codes
  localparam logic [2:0] EV_SERIES  = 3'd0;
  localparam logic [2:0] EV_BODY    = 3'd1;
  localparam logic [2:0] EV_INIT    = 3'd2;
  localparam logic [2:0] EV_HEADER  = 3'd3;
  localparam logic [2:0] EV_BADTYPE = 3'd4;

  // Message kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_GATH  = 2'd1;
  localparam logic [1:0] KIND_BCAST = 2'd2;

  // Class of a byte if it were seen in place of a type byte
  typedef enum logic [2:0] {
    CLS_INIT,
    CLS_GATH,
    CLS_BCAST,
    CLS_KEEP,
    CLS_OTHER
  } byte_class_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        chunk_end;
    byte_class_e cls;
  } tok_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [1:0]  msg_kind;
    logic [31:0] value;
    logic [31:0] position;
    logic        last;
  } res_t;

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e c;
    c = CLS_OTHER;
    if (b == TYPE_INIT) begin
      c = CLS_INIT;
    end else if (b == TYPE_GATH) begin
      c = CLS_GATH;
    end else if (b == TYPE_BCAST) begin
      c = CLS_BCAST;
    end else if (b == TYPE_KEEP) begin
      c = CLS_KEEP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/msd_front.sv =====
// ----------------------------------------------------------------------------
// msd_front
// Accepts stream bytes, tags each with its type-byte class and holds them
// in a two-entry queue for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push,
  output logic            full,
  input  wire  [7:0]      data_byte_i,
  input  wire             chunk_end_i,
  output logic            tok_valid_o,
  output msd_pkg::tok_t   tok_o,
  input  wire             tok_take_i
);

  msd_pkg::tok_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          wr_en;
  logic          rd_en;

  assign full        = (count_q == 2'd2);
  assign tok_valid_o = (count_q != 2'd0);
  assign tok_o       = slot_q[rd_ptr_q];

  assign wr_en = push && !full;
  assign rd_en = tok_take_i && tok_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (rd_en) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({wr_en, rd_en})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q].data_byte <= data_byte_i;
      slot_q[wr_ptr_q].chunk_end <= chunk_end_i;
      slot_q[wr_ptr_q].cls       <= msd_pkg::classify(data_byte_i);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msd_back.sv =====
// ----------------------------------------------------------------------------
// msd_back
// Parser state machine: walks each message layout byte by byte and
// produces at most one result per request taken.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             tok_valid_i,
  input  msd_pkg::tok_t   tok_i,
  output logic            tok_take_o,
  input  wire             res_full_i,
  output logic            res_push_o,
  output msd_pkg::res_t   res_o
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_RANK    = 4'd1;
  localparam logic [3:0] PH_SLEN    = 4'd2;
  localparam logic [3:0] PH_SERIES  = 4'd3;
  localparam logic [3:0] PH_BLEN    = 4'd4;
  localparam logic [3:0] PH_BODY    = 4'd5;
  localparam logic [3:0] PH_DISCARD = 4'd6;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  series_q, series_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] index_q, index_d;

  logic [31:0] accum_shift;
  logic [31:0] idx_inc;
  logic [7:0]  b;

  assign tok_take_o  = tok_valid_i && !res_full_i;
  assign b           = tok_i.data_byte;
  assign accum_shift = {accum_q[23:0], b};
  assign idx_inc     = index_q + 32'd1;

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    series_d   = series_q;
    accum_d    = accum_q;
    index_d    = index_q;
    res_push_o = 1'b0;
    res_o      = '0;
    if (tok_take_o) begin
      unique case (phase_q)
        PH_RANK: begin
          accum_d = accum_shift;
          index_d = idx_inc;
          if (idx_inc >= 32'd4) begin
            phase_d  = PH_IDLE;
            kind_d   = msd_pkg::KIND_INIT;
            series_d = 8'd0;
            accum_d  = 32'd0;
            index_d  = 32'd0;
            res_push_o      = 1'b1;
            res_o.event_res = msd_pkg::EV_INIT;
            res_o.msg_kind  = msd_pkg::KIND_INIT;
            res_o.value     = accum_shift;
            res_o.last      = 1'b1;
          end
        end
        PH_SLEN: begin
          series_d = b;
          index_d  = 32'd0;
          accum_d  = 32'd0;
          phase_d  = (b == 8'd0) ? PH_BLEN : PH_SERIES;
        end
        PH_SERIES: begin
          index_d = idx_inc;
          if (idx_inc >= {24'd0, series_q}) begin
            index_d = 32'd0;
            accum_d = 32'd0;
            phase_d = PH_BLEN;
          end
          res_push_o      = 1'b1;
          res_o.event_res = msd_pkg::EV_SERIES;
          res_o.msg_kind  = kind_q;
          res_o.value     = {24'd0, b};
          res_o.position  = index_q;
        end
        PH_BLEN: begin
          accum_d = accum_shift;
          index_d = idx_inc;
          if (idx_inc >= 32'd4) begin
            index_d         = 32'd0;
            res_push_o      = 1'b1;
            res_o.event_res = msd_pkg::EV_HEADER;
            res_o.msg_kind  = kind_q;
            res_o.value     = accum_shift;
            if (accum_shift == 32'd0) begin
              // empty body: header closes the message
              phase_d    = PH_IDLE;
              kind_d     = msd_pkg::KIND_INIT;
              series_d   = 8'd0;
              accum_d    = 32'd0;
              res_o.last = 1'b1;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          res_push_o      = 1'b1;
          res_o.event_res = msd_pkg::EV_BODY;
          res_o.msg_kind  = kind_q;
          res_o.value     = {24'd0, b};
          res_o.position  = index_q;
          if (idx_inc >= accum_q) begin
            res_o.last = 1'b1;
            phase_d    = PH_IDLE;
            kind_d     = msd_pkg::KIND_INIT;
            series_d   = 8'd0;
            accum_d    = 32'd0;
            index_d    = 32'd0;
          end else begin
            index_d = idx_inc;
          end
        end
        PH_DISCARD: begin
          if (tok_i.chunk_end) begin
            phase_d  = PH_IDLE;
            kind_d   = msd_pkg::KIND_INIT;
            series_d = 8'd0;
            accum_d  = 32'd0;
            index_d  = 32'd0;
          end
        end
        default: begin
          // idle, and any unused phase code
          phase_d  = PH_IDLE;
          kind_d   = msd_pkg::KIND_INIT;
          series_d = 8'd0;
          accum_d  = 32'd0;
          index_d  = 32'd0;
          unique case (tok_i.cls)
            msd_pkg::CLS_INIT: begin
              phase_d = PH_RANK;
            end
            msd_pkg::CLS_GATH: begin
              kind_d  = msd_pkg::KIND_GATH;
              phase_d = PH_SLEN;
            end
            msd_pkg::CLS_BCAST: begin
              kind_d  = msd_pkg::KIND_BCAST;
              phase_d = PH_SLEN;
            end
            msd_pkg::CLS_KEEP: begin
              phase_d = PH_IDLE;
            end
            default: begin
              if (!tok_i.chunk_end) begin
                phase_d = PH_DISCARD;
              end
              res_push_o      = 1'b1;
              res_o.event_res = msd_pkg::EV_BADTYPE;
              res_o.value     = {24'd0, b};
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      kind_q   <= 2'd0;
      series_q <= 8'd0;
      accum_q  <= 32'd0;
      index_q  <= 32'd0;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      series_q <= series_d;
      accum_q  <= accum_d;
      index_q  <= index_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msd_out_queue.sv =====
// ----------------------------------------------------------------------------
// msd_out_queue
// Two-entry result queue between the parser and the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_out_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             res_push_i,
  input  msd_pkg::res_t   res_i,
  output logic            res_full_o,
  output logic            empty,
  input  wire             pop,
  output msd_pkg::res_t   res_o
);

  msd_pkg::res_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          wr_en;
  logic          rd_en;

  assign res_full_o = (count_q == 2'd2);
  assign empty      = (count_q == 2'd0);
  assign res_o      = slot_q[rd_ptr_q];

  assign wr_en = res_push_i && !res_full_o;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_en) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (rd_en) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({wr_en, rd_en})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/message_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// message_stream_deframer
// Splits a byte stream into init, gather and broadcast messages; series and
// body bytes leave with their index, bad type bytes are reported.
// ----------------------------------------------------------------------------
// A request is registered in the input queue, its result in the result queue.
// Throughput: one byte per cycle while the result queue is not full.
// Both full: a pop frees a result slot, a byte moves on, then full falls.
// Reset (rst_ni low, async): queues empty, parser idle awaiting a type byte.
`default_nettype none

module message_stream_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  data_byte_i,
  input  wire         chunk_end_i,
  output logic        empty,
  input  wire         pop,
  output logic [2:0]  event_res_o,
  output logic [1:0]  msg_kind_o,
  output logic [31:0] value_o,
  output logic [31:0] position_o,
  output logic        last_o
);

  logic          tok_valid;
  msd_pkg::tok_t tok;
  logic          tok_take;
  logic          res_full;
  logic          res_push;
  msd_pkg::res_t res_in;
  msd_pkg::res_t res_out;

  msd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .chunk_end_i (chunk_end_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_take_i  (tok_take)
  );

  msd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_take_o  (tok_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  msd_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign event_res_o = res_out.event_res;
  assign msg_kind_o  = res_out.msg_kind;
  assign value_o     = res_out.value;
  assign position_o  = res_out.position;
  assign last_o      = res_out.last;

endmodule

`default_nettype wire

// ===== sim/message_stream_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// message_stream_deframer_checker
// Watches both queue ports of the deframer, predicts the results of the
// accepted bytes with its own parser, compares each popped result field by
// field. Mismatches and stray results are counted for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module message_stream_deframer_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  input  wire         full_i,
  input  wire  [7:0]  data_byte_i,
  input  wire         chunk_end_i,
  input  wire         empty_i,
  input  wire         pop_i,
  input  wire  [2:0]  event_res_i,
  input  wire  [1:0]  msg_kind_i,
  input  wire  [31:0] value_i,
  input  wire  [31:0] position_i,
  input  wire         last_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANK,
    ST_SLEN,
    ST_SERIES,
    ST_BLEN,
    ST_BODY,
    ST_DISCARD
  } parse_state_e;

  parse_state_e state_q;
  logic [1:0]   kind_q;
  logic [7:0]   series_len_q;
  logic [31:0]  accum_q;
  logic [31:0]  index_q;

  msd_pkg::res_t expected_results[$];
  int unsigned   mismatch_count;

  task automatic clear_parser();
    state_q      = ST_IDLE;
    kind_q       = msd_pkg::KIND_INIT;
    series_len_q = '0;
    accum_q      = '0;
    index_q      = '0;
  endtask

  task automatic expect_result(input logic [2:0] ev, input logic [1:0] kind,
                               input logic [31:0] val, input logic [31:0] pos,
                               input logic lst);
    msd_pkg::res_t r;
    r.event_res = ev;
    r.msg_kind  = kind;
    r.value     = val;
    r.position  = pos;
    r.last      = lst;
    expected_results.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic ce);
    logic [31:0] len;
    logic        lst;
    case (state_q)
      ST_RANK: begin
        accum_q = {accum_q[23:0], b};
        index_q++;
        if (index_q >= 32'd4) begin
          len = accum_q;
          clear_parser();
          expect_result(msd_pkg::EV_INIT, msd_pkg::KIND_INIT, len, '0, 1'b1);
        end
      end
      ST_SLEN: begin
        series_len_q = b;
        index_q      = '0;
        accum_q      = '0;
        state_q      = (b == 8'd0) ? ST_BLEN : ST_SERIES;
      end
      ST_SERIES: begin
        expect_result(msd_pkg::EV_SERIES, kind_q, {24'd0, b}, index_q, 1'b0);
        index_q++;
        if (index_q >= {24'd0, series_len_q}) begin
          index_q = '0;
          accum_q = '0;
          state_q = ST_BLEN;
        end
      end
      ST_BLEN: begin
        accum_q = {accum_q[23:0], b};
        index_q++;
        if (index_q >= 32'd4) begin
          index_q = '0;
          if (accum_q == '0) begin
            expect_result(msd_pkg::EV_HEADER, kind_q, '0, '0, 1'b1);
            clear_parser();
          end else begin
            state_q = ST_BODY;
            expect_result(msd_pkg::EV_HEADER, kind_q, accum_q, '0, 1'b0);
          end
        end
      end
      ST_BODY: begin
        // index + 1 wraps at 32 bits
        lst = ((index_q + 32'd1) >= accum_q);
        expect_result(msd_pkg::EV_BODY, kind_q, {24'd0, b}, index_q, lst);
        if (lst) begin
          clear_parser();
        end else begin
          index_q++;
        end
      end
      ST_DISCARD: begin
        if (ce) begin
          clear_parser();
        end
      end
      default: begin
        clear_parser();
        case (b)
          msd_pkg::TYPE_INIT: begin
            kind_q  = msd_pkg::KIND_INIT;
            state_q = ST_RANK;
          end
          msd_pkg::TYPE_GATH: begin
            kind_q  = msd_pkg::KIND_GATH;
            state_q = ST_SLEN;
          end
          msd_pkg::TYPE_BCAST: begin
            kind_q  = msd_pkg::KIND_BCAST;
            state_q = ST_SLEN;
          end
          msd_pkg::TYPE_KEEP: ;
          default: begin
            // discard runs to the end of the chunk unless this byte ends it
            if (!ce) begin
              state_q = ST_DISCARD;
            end
            expect_result(msd_pkg::EV_BADTYPE, msd_pkg::KIND_INIT, {24'd0, b}, '0,
                          1'b0);
          end
        endcase
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    msd_pkg::res_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing predicted: event_res 0x%0h value 0x%0h",
             event_res_i, value_i);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("event_res", {29'd0, want.event_res}, {29'd0, event_res_i});
      compare_field("msg_kind", {30'd0, want.msg_kind}, {30'd0, msg_kind_i});
      compare_field("value", want.value, value_i);
      compare_field("position", want.position, position_i);
      compare_field("last", {31'd0, want.last}, {31'd0, last_i});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
      mismatch_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // a result never leaves in the cycle of its own request
      if (pop_i && !empty_i) begin
        check_result();
      end
      if (push_i && !full_i) begin
        parse_byte(data_byte_i, chunk_end_i);
      end
      mismatches_o <= mismatch_count;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// ===== sim/message_stream_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// message_stream_deframer_tb
// Feeds the deframer a byte stream of init, gather, broadcast, keepalive and
// bad-type messages, first directed then random, under varying sender idling
// and receiver stalls, with one long receiver hold-off to fill the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module message_stream_deframer_tb;

  localparam int unsigned STREAM_BYTES  = 1900;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        chunk_end;
  logic        empty;
  logic        pop;
  logic [2:0]  event_res;
  logic [1:0]  msg_kind;
  logic [31:0] value;
  logic [31:0] position;
  logic        last;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned ce_rate;
  logic        hold_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  message_stream_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .chunk_end_i (chunk_end),
    .empty       (empty),
    .pop         (pop),
    .event_res_o (event_res),
    .msg_kind_o  (msg_kind),
    .value_o     (value),
    .position_o  (position),
    .last_o      (last)
  );

  message_stream_deframer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .data_byte_i  (data_byte),
    .chunk_end_i  (chunk_end),
    .empty_i      (empty),
    .pop_i        (pop),
    .event_res_i  (event_res),
    .msg_kind_i   (msg_kind),
    .value_i      (value),
    .position_i   (position),
    .last_i       (last),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Watchdog: cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    logic held;
    held = 1'b0;
    pop  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rst_ni) begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic rand_ce();
    return ($urandom_range(99) < ce_rate);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic ce);
    while ($urandom_range(99) < tx_idle_pct) begin
      push      <= 1'b0;
      data_byte <= 8'($urandom);
      chunk_end <= 1'($urandom);
      @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    chunk_end <= ce;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_init(input logic [31:0] rank);
    send_byte(msd_pkg::TYPE_INIT, rand_ce());
    for (int k = 3; k >= 0; k--) begin
      send_byte(rank[8*k +: 8], rand_ce());
    end
  endtask

  task automatic send_message(input logic [7:0] type_b, input logic [7:0] slen,
                              input logic [31:0] blen);
    send_byte(type_b, rand_ce());
    send_byte(slen, rand_ce());
    for (int i = 0; i < slen; i++) begin
      send_byte(8'($urandom), rand_ce());
    end
    for (int k = 3; k >= 0; k--) begin
      send_byte(blen[8*k +: 8], rand_ce());
    end
    for (int unsigned i = 0; i < blen; i++) begin
      send_byte(8'($urandom), rand_ce());
    end
  endtask

  // Bad type byte; if it does not end the chunk, noise follows up to the end
  task automatic send_bad(input logic [7:0] b, input logic first_ce,
                          input int unsigned noise_n);
    send_byte(b, first_ce);
    if (!first_ce) begin
      repeat (noise_n) send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  function automatic logic is_type_byte(input logic [7:0] b);
    return (b == msd_pkg::TYPE_INIT) || (b == msd_pkg::TYPE_GATH) ||
           (b == msd_pkg::TYPE_BCAST) || (b == msd_pkg::TYPE_KEEP);
  endfunction

  initial begin : stimulus
    logic [7:0]  b;
    logic [7:0]  slen;
    logic [31:0] blen;
    logic [31:0] rank;
    int unsigned pick;
    int unsigned mode;
    logic        hold_done;

    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte    = '0;
    chunk_end    = 1'b0;
    hold_req     = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    ce_rate      = 0;
    bytes_sent   = 0;
    hold_done    = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full rank, empty series and body split at every byte,
    // minimal broadcast, keepalive, bad type at and before a chunk end,
    // init whose rank straddles a chunk end
    send_init(32'hFFFF_FFFF);
    ce_rate = 100;
    send_message(msd_pkg::TYPE_GATH, 8'd0, 32'd0);
    ce_rate = 0;
    send_message(msd_pkg::TYPE_BCAST, 8'd1, 32'd1);
    send_byte(msd_pkg::TYPE_KEEP, 1'b0);
    send_bad(8'h00, 1'b1, 0);
    send_bad(8'hFF, 1'b0, 0);
    send_byte(msd_pkg::TYPE_INIT, 1'b0);
    send_byte(8'h5A, 1'b1);
    repeat (3) send_byte(8'($urandom), 1'b0);

    ce_rate = 12;
    while (bytes_sent < STREAM_BYTES) begin
      mode = (bytes_sent * 4) / STREAM_BYTES;
      case (mode)
        0: begin
          tx_idle_pct  <= 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct  <= 46;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct  <= 0;
          rx_stall_pct <= 46;
        end
        default: begin
          tx_idle_pct  <= 37;
          rx_stall_pct <= 37;
        end
      endcase

      if (mode == 0 && !hold_done && bytes_sent > 150) begin
        // receiver holds off while a long body keeps arriving
        hold_done = 1'b1;
        hold_req <= 1'b1;
        send_message(msd_pkg::TYPE_BCAST, 8'd2, 32'd200);
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          slen = ($urandom_range(29) == 0) ? 8'd255 : 8'($urandom_range(6));
          blen = ($urandom_range(29) == 0) ? 32'($urandom_range(300, 40))
                                           : 32'($urandom_range(12));
          send_message($urandom_range(1) ? msd_pkg::TYPE_GATH : msd_pkg::TYPE_BCAST,
                       slen, blen);
        end else if (pick < 65) begin
          case ($urandom_range(5))
            0:       rank = '0;
            1:       rank = 32'hFFFF_FFFF;
            default: rank = $urandom;
          endcase
          send_init(rank);
        end else if (pick < 75) begin
          send_byte(msd_pkg::TYPE_KEEP, rand_ce());
        end else if (pick < 90) begin
          do begin
            b = 8'($urandom);
          end while (is_type_byte(b));
          send_bad(b, $urandom_range(3) == 0, $urandom_range(5));
        end else begin
          // stray byte in place of a type byte, never opening a message
          b = 8'($urandom);
          if (is_type_byte(b)) begin
            send_byte(msd_pkg::TYPE_KEEP, rand_ce());
          end else begin
            send_bad(b, rand_ce(), $urandom_range(3));
          end
        end
      end
    end
    push <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/msd_pkg.sv
hdl/msd_front.sv
hdl/msd_back.sv
hdl/msd_out_queue.sv
hdl/message_stream_deframer.sv
sim/message_stream_deframer_checker.sv
sim/message_stream_deframer_tb.sv
